>>> rtl/cb64_pkg.sv
package cb64_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} char_item_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_status;
		logic [2:0] status;
		logic       last;
	} res_item_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
	localparam logic [2:0] ST_BAD_PAD    = 3'd2;
	localparam logic [2:0] ST_TRAIL_BITS = 3'd3;
	localparam logic [2:0] ST_LENGTH     = 3'd4;
	localparam logic [2:0] ST_TOO_MANY   = 3'd5;

	localparam logic [7:0]  PAD_CHAR      = 8'h3D;
	localparam int          MAX_BYTES_W   = 24;
	localparam logic [23:0] MAX_BYTES_RST = 24'hFFFFFF;

	// Bit 6 set means the character is not in the standard alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r = 7'd62;
		end else if (c == 8'h2F) begin
			r = 7'd63;
		end
		return r;
	endfunction

endpackage

>>> rtl/canonical_base64_decoder.sv
// Strict base64 decoder, one character per transfer on the char channel.
// The character flagged end_of_text closes a string. Each completed quartet
// yields one to three data bytes on the res channel; the closing character
// is followed by one status item (is_status and last set, status code).
// Data bytes of a string are only valid if its closing status is zero.
// The max_bytes limit is written over the cfg channel, by the user only while
// the block idles; the block does not enforce this. cfg_ready is always high.
// A character is registered at acceptance; its results are loaded into the
// result buffer when it is consumed and are offered on res from that buffer.
// Throughput: one character per cycle. The result buffer holds the up to
// four results of one character and drains one per cycle, so a character
// that produces results waits in the input register only while earlier
// results are still being delivered; four characters yield at most three bytes.
// When the receiver stalls, the result buffer holds and char_stall rises
// as soon as a character with results is waiting behind it.
// Reset clears all string state and sets max_bytes to its largest value.
module canonical_base64_decoder #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  cb64_pkg::char_item_t  char_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output cb64_pkg::res_item_t   res_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [cb64_pkg::MAX_BYTES_W-1:0] cfg_max_bytes
);

	localparam int CMPW = (COUNT_WIDTH > cb64_pkg::MAX_BYTES_W ?
		COUNT_WIDTH : cb64_pkg::MAX_BYTES_W) + 1;

	logic                          valid_s1;
	cb64_pkg::char_item_t          item_s1;

	logic [cb64_pkg::MAX_BYTES_W-1:0] max_bytes_q;
	logic [1:0]                    pos_q;
	logic [17:0]                   acc_q;
	logic                          tpad_q;
	logic [2:0]                    err_q;
	logic [COUNT_WIDTH-1:0]        cnt_q;

	logic [7:0]                    b_q [3];
	logic [1:0]                    ndata_q;
	logic [2:0]                    stat_q;
	logic [2:0]                    left_q;
	logic [1:0]                    idx_q;

	logic [6:0]                    sx;
	logic                          pad;
	logic                          invalid;
	logic [5:0]                    vv;
	logic [23:0]                   packed_w;
	logic [1:0]                    pads;
	logic [1:0]                    nbytes;
	logic [COUNT_WIDTH:0]          sum;
	logic                          too_many;
	logic                          trail;
	logic                          emit;
	logic [2:0]                    e;
	logic [2:0]                    err_n;
	logic [1:0]                    pos_n;
	logic [17:0]                   acc_n;
	logic                          tpad_n;
	logic [COUNT_WIDTH-1:0]        cnt_n;
	logic [1:0]                    ndata_n;
	logic [2:0]                    nres;

	logic                          res_xfer;
	logic                          buf_free;
	logic                          consume;
	logic                          char_xfer;

	assign cfg_ready = 1'b1;

	always_comb begin
		sx       = cb64_pkg::sextet_of(item_s1.char_code);
		pad      = item_s1.char_code == cb64_pkg::PAD_CHAR;
		invalid  = !pad && sx[6];
		vv       = (pad || invalid) ? 6'd0 : sx[5:0];
		packed_w = {acc_q, vv};
		pads     = 2'(tpad_q) + 2'(pad);
		nbytes   = 2'd3 - pads;
		sum      = {1'b0, cnt_q} + (COUNT_WIDTH+1)'(nbytes);
		too_many = sum[COUNT_WIDTH] || (CMPW'(sum) > CMPW'(max_bytes_q));
		trail    = (pads == 2'd2 && packed_w[15:8] != 8'd0) ||
			(pads == 2'd1 && packed_w[7:0] != 8'd0);
		e        = err_q;
		pos_n    = pos_q;
		acc_n    = acc_q;
		tpad_n   = tpad_q;
		cnt_n    = cnt_q;
		emit     = 1'b0;

		if (invalid && e == cb64_pkg::ST_OK) begin
			e = cb64_pkg::ST_BAD_CHAR;
		end
		if (pad) begin
			if (pos_q < 2'd2) begin
				if (e == cb64_pkg::ST_OK) begin
					e = cb64_pkg::ST_BAD_PAD;
				end
			end else if (pos_q == 2'd2) begin
				tpad_n = 1'b1;
			end
		end else if (pos_q == 2'd3 && tpad_q && e == cb64_pkg::ST_OK) begin
			e = cb64_pkg::ST_BAD_PAD;
		end

		if (pos_q != 2'd3) begin
			acc_n = {acc_q[11:0], vv};
			pos_n = pos_q + 2'd1;
		end else begin
			if (pads != 2'd0 && !item_s1.end_of_text && e == cb64_pkg::ST_OK) begin
				e = cb64_pkg::ST_BAD_PAD;
			end
			if (e == cb64_pkg::ST_OK && too_many) begin
				e = cb64_pkg::ST_TOO_MANY;
			end
			if (e == cb64_pkg::ST_OK && trail) begin
				e = cb64_pkg::ST_TRAIL_BITS;
			end
			if (e == cb64_pkg::ST_OK) begin
				emit  = 1'b1;
				cnt_n = sum[COUNT_WIDTH-1:0];
			end
			pos_n  = 2'd0;
			acc_n  = 18'd0;
			tpad_n = 1'b0;
		end

		if (item_s1.end_of_text && pos_n != 2'd0 && e == cb64_pkg::ST_OK) begin
			e = cb64_pkg::ST_LENGTH;
		end
		err_n = e;
		if (item_s1.end_of_text) begin
			err_n  = cb64_pkg::ST_OK;
			pos_n  = 2'd0;
			acc_n  = 18'd0;
			tpad_n = 1'b0;
			cnt_n  = '0;
		end
		ndata_n = emit ? nbytes : 2'd0;
		nres    = 3'(ndata_n) + 3'(item_s1.end_of_text);
	end

	assign res_xfer   = res_valid && !res_stall;
	assign buf_free   = (left_q == 3'd0) || (left_q == 3'd1 && res_xfer);
	assign consume    = valid_s1 && (nres == 3'd0 || buf_free);
	assign char_stall = valid_s1 && !consume;
	assign char_xfer  = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			max_bytes_q <= cb64_pkg::MAX_BYTES_RST;
			pos_q       <= 2'd0;
			acc_q       <= 18'd0;
			tpad_q      <= 1'b0;
			err_q       <= cb64_pkg::ST_OK;
			cnt_q       <= '0;
			left_q      <= 3'd0;
			idx_q       <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_bytes_q <= cfg_max_bytes;
			end
			if (char_xfer) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				pos_q  <= pos_n;
				acc_q  <= acc_n;
				tpad_q <= tpad_n;
				err_q  <= err_n;
				cnt_q  <= cnt_n;
			end
			if (consume && nres != 3'd0) begin
				left_q <= nres;
				idx_q  <= 2'd0;
			end else if (res_xfer) begin
				left_q <= left_q - 3'd1;
				idx_q  <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_xfer) begin
			item_s1 <= char_item;
		end
		if (consume && nres != 3'd0) begin
			b_q[0]  <= packed_w[23:16];
			b_q[1]  <= packed_w[15:8];
			b_q[2]  <= packed_w[7:0];
			ndata_q <= ndata_n;
			stat_q  <= e;
		end
	end

	// Buffer entries below the data count are bytes; the one after is the status.
	always_comb begin
		res_valid = left_q != 3'd0;
		if (idx_q < ndata_q) begin
			res_item.byte_value = b_q[idx_q];
			res_item.is_status  = 1'b0;
			res_item.status     = cb64_pkg::ST_OK;
			res_item.last       = 1'b0;
		end else begin
			res_item.byte_value = 8'd0;
			res_item.is_status  = 1'b1;
			res_item.status     = stat_q;
			res_item.last       = 1'b1;
		end
	end

endmodule

>>> rtl/cb64_chk.sv
module cb64_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  char_valid,
	input logic                  char_stall,
	input cb64_pkg::char_item_t  char_item,
	input logic                  res_valid,
	input logic                  res_stall,
	input cb64_pkg::res_item_t   res_item,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [cb64_pkg::MAX_BYTES_W-1:0] cfg_max_bytes
);

	// A stalled result stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.is_status |->
			!res_item.last && res_item.status == cb64_pkg::ST_OK)
		else $error("data item carries status fields");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.is_status |->
			res_item.last && res_item.byte_value == 8'd0 &&
			res_item.status <= cb64_pkg::ST_TOO_MANY)
		else $error("malformed status item");

	// An empty result buffer only fills from a character taken in through the input register.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(char_valid && !char_stall, 2))
		else $error("result appeared without a character in flight");

endmodule

bind canonical_base64_decoder cb64_chk u_cb64_chk (.*);
